/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file cgma_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only outside reset.
`define CHECK_RUN(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every edge, reset included.
`define CHECK_ALL(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/cgma_pkg.sv */
// Package: types, constants and tables for the gradient magnitude / azimuth block.
package cgma_pkg;

   localparam int DataWidth    = 32;
   localparam int CordicStages = 16;
   localparam int SqrtSteps    = 32;
   localparam int StepWidth    = 5;
   localparam int ModeMag      = 0;

   localparam logic signed [31:0] Deg90  = 32'sd5898240;
   localparam logic signed [31:0] Deg180 = 32'sd11796480;
   localparam logic [31:0]        MagLimit = 32'((64'd1 << (DataWidth - 1)) - 64'd1);

   typedef enum logic {
      REG_OUTPUT_MODE   = 1'b0,
      REG_STEP_DISTANCE = 1'b1
   } cgma_reg_type;

   typedef struct packed {
      logic               mode;
      logic               neg;
      logic signed [31:0] crl;
      logic signed [31:0] inl;
   } cgma_diff_type;

   typedef struct packed {
      logic               mode;
      logic               neg;
      logic               zero;
      logic [63:0]        n;
      logic [34:0]        rem;
      logic [31:0]        root;
      logic signed [35:0] x;
      logic signed [35:0] y;
      logic signed [31:0] z;
   } cgma_iter_type;

   // floor(2^31 / s): reciprocal of 2*s scaled by 2^32
   function automatic logic [31:0] recip(input logic [4:0] s);
      logic [31:0] r;
      case (s)
         5'd1:    r = 32'd2147483648;
         5'd2:    r = 32'd1073741824;
         5'd3:    r = 32'd715827882;
         5'd4:    r = 32'd536870912;
         5'd5:    r = 32'd429496729;
         5'd6:    r = 32'd357913941;
         5'd7:    r = 32'd306783378;
         5'd8:    r = 32'd268435456;
         5'd9:    r = 32'd238609294;
         5'd10:   r = 32'd214748364;
         5'd11:   r = 32'd195225786;
         5'd12:   r = 32'd178956970;
         5'd13:   r = 32'd165191049;
         5'd14:   r = 32'd153391689;
         5'd15:   r = 32'd143165576;
         default: r = 32'd134217728;
      endcase
      return r;
   endfunction

   // atan(2^-i) in degrees, Q15.16
   function automatic logic signed [31:0] atan_deg(input int i);
      logic signed [31:0] a;
      case (i)
         0:       a = 32'sd2949120;
         1:       a = 32'sd1740967;
         2:       a = 32'sd919879;
         3:       a = 32'sd466945;
         4:       a = 32'sd234379;
         5:       a = 32'sd117304;
         6:       a = 32'sd58666;
         7:       a = 32'sd29335;
         8:       a = 32'sd14668;
         9:       a = 32'sd7334;
         10:      a = 32'sd3667;
         11:      a = 32'sd1833;
         12:      a = 32'sd917;
         13:      a = 32'sd458;
         14:      a = 32'sd229;
         15:      a = 32'sd115;
         16:      a = 32'sd57;
         17:      a = 32'sd29;
         18:      a = 32'sd14;
         19:      a = 32'sd7;
         20:      a = 32'sd4;
         21:      a = 32'sd2;
         22:      a = 32'sd1;
         default: a = 32'sd0;
      endcase
      return a;
   endfunction

endpackage

/* hw/rtl/cgma_diff.sv */
// Three-stage front end: differences, reciprocal multiply, quotient correction.
module cgma_diff
   import cgma_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [31:0]          cross_back,
   input  logic [31:0]          cross_fwd,
   input  logic [31:0]          inline_back,
   input  logic [31:0]          inline_fwd,
   input  logic                 mode,
   input  logic [StepWidth-1:0] step_raw,
   output logic                 out_valid,
   output cgma_diff_type        out_data
);

   logic               v1_ff, v2_ff, v3_ff;
   logic               mode1_ff, mode2_ff;
   logic               neg1_ff, neg2_ff;
   logic signed [32:0] dc1_ff, di1_ff;
   logic [4:0]         s1_ff;
   logic [5:0]         d2_ff;
   logic [31:0]        ac2_ff, ai2_ff, qc2_ff, qi2_ff;
   logic               sc2_ff, si2_ff;
   cgma_diff_type      out_ff;

   logic [4:0]         s_in;
   logic               negc_in, negi_in;
   logic signed [32:0] dc_in, di_in;
   logic [31:0]        ac_in, ai_in, r_in;
   logic [63:0]        pc_in, pi_in;
   logic [37:0]        rc_in, ri_in;
   logic [31:0]        qc_in, qi_in;
   cgma_diff_type      out_in;

   function automatic logic pair_nonpos(input logic [31:0] a, input logic [31:0] b);
      return (a == 32'd0) || (b == 32'd0) || (a[31] != b[31]);
   endfunction

   always_comb begin
      if (step_raw == 5'd0) begin
         s_in = 5'd1;
      end else if (step_raw > 5'd16) begin
         s_in = 5'd16;
      end else begin
         s_in = step_raw;
      end
      negc_in = pair_nonpos(cross_fwd, cross_back);
      negi_in = pair_nonpos(inline_fwd, inline_back);
      dc_in = $signed({cross_fwd[31], cross_fwd}) - $signed({cross_back[31], cross_back});
      di_in = $signed({inline_fwd[31], inline_fwd}) - $signed({inline_back[31], inline_back});
   end

   always_comb begin
      ac_in = dc1_ff[32] ? 32'(-dc1_ff) : dc1_ff[31:0];
      ai_in = di1_ff[32] ? 32'(-di1_ff) : di1_ff[31:0];
      r_in  = recip(s1_ff);
      pc_in = 64'(ac_in) * 64'(r_in);
      pi_in = 64'(ai_in) * 64'(r_in);
   end

   always_comb begin
      rc_in = 38'(ac2_ff) - 38'(qc2_ff) * 38'(d2_ff);
      ri_in = 38'(ai2_ff) - 38'(qi2_ff) * 38'(d2_ff);
      qc_in = (rc_in >= 38'(d2_ff)) ? qc2_ff + 32'd1 : qc2_ff;
      qi_in = (ri_in >= 38'(d2_ff)) ? qi2_ff + 32'd1 : qi2_ff;
      out_in.mode = mode2_ff;
      out_in.neg  = neg2_ff;
      out_in.crl  = sc2_ff ? -$signed(qc_in) : $signed(qc_in);
      out_in.inl  = si2_ff ? -$signed(qi_in) : $signed(qi_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode1_ff <= mode;
         neg1_ff  <= negc_in | negi_in;
         dc1_ff   <= dc_in;
         di1_ff   <= di_in;
         s1_ff    <= s_in;
         mode2_ff <= mode1_ff;
         neg2_ff  <= neg1_ff;
         d2_ff    <= {s1_ff, 1'b0};
         ac2_ff   <= ac_in;
         ai2_ff   <= ai_in;
         qc2_ff   <= pc_in[63:32];
         qi2_ff   <= pi_in[63:32];
         sc2_ff   <= dc1_ff[32];
         si2_ff   <= di1_ff[32];
         out_ff   <= out_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = out_ff;

endmodule

/* hw/rtl/cgma_iter.sv */
// One pipeline stage: a root digit step and, while in range, a CORDIC rotation.
module cgma_iter
   import cgma_pkg::*;
#(
   parameter int INDEX         = 0,
   parameter int CORDIC_STAGES = CordicStages
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  cgma_iter_type in_data,
   output logic          out_valid,
   output cgma_iter_type out_data
);

   logic          v_ff;
   cgma_iter_type d_ff;
   cgma_iter_type d_in;
   logic [36:0]   t_in, trial_in;
   logic signed [35:0] dx_in, dy_in;

   always_comb begin
      d_in     = in_data;
      t_in     = {in_data.rem, in_data.n[63:62]};
      trial_in = {3'b000, in_data.root, 2'b01};
      d_in.n   = {in_data.n[61:0], 2'b00};
      if (t_in >= trial_in) begin
         d_in.rem  = 35'(t_in - trial_in);
         d_in.root = {in_data.root[30:0], 1'b1};
      end else begin
         d_in.rem  = t_in[34:0];
         d_in.root = {in_data.root[30:0], 1'b0};
      end
      dx_in = in_data.y >>> INDEX;
      dy_in = in_data.x >>> INDEX;
      if (INDEX < CORDIC_STAGES) begin
         if (!in_data.y[35]) begin
            d_in.x = in_data.x + dx_in;
            d_in.y = in_data.y - dy_in;
            d_in.z = in_data.z + atan_deg(INDEX);
         end else begin
            d_in.x = in_data.x - dx_in;
            d_in.y = in_data.y + dy_in;
            d_in.z = in_data.z - atan_deg(INDEX);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in;
      end
   end

   assign out_valid = v_ff;
   assign out_data  = d_ff;

endmodule

/* hw/rtl/curvature_gradient_magnitude_azimuth.sv */
// Top level: signed gradient magnitude or azimuth from four neighbour values.
//
// Usage:
//   req_*  : one transaction carries the four Q15.16 neighbours of a centre point.
//   rsp_*  : one transaction per input, a signed Q15.16 magnitude (mode 0)
//            or the azimuth in Q15.16 degrees (mode 1).
//   csr_*  : register writes, index 0 output_mode, index 1 step_distance;
//            always ready, write only while no transaction is in flight.
// rsp_tvalid rises once a transaction has passed all 37 register
// stages: 3 front-end (difference, reciprocal multiply, correction),
// 1 square stage, 32 root digit stages (CORDIC rides along in the first
// CORDIC_STAGES of them), 1 output stage. Throughput is one transaction
// per cycle while rsp_tready does not hold the pipeline.
// All stages move on one shared enable; when rsp_tready is low with a
// result waiting, req_tready drops and the whole pipeline holds, nothing
// is lost or repeated.
// Synchronous reset clears all valid bits and loads output_mode 0 and
// step_distance 1.
module curvature_gradient_magnitude_azimuth
   import cgma_pkg::*;
#(
   parameter int CORDIC_STAGES = CordicStages
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // cross_back, cross_fwd, inline_back, inline_fwd
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // result_value
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [4:0]   csr_data
);

   logic                 mode_ff;
   logic [StepWidth-1:0] step_ff;
   logic                 en;

   logic          dv;
   cgma_diff_type dd;

   logic               sv_ff;
   logic               smode_ff, sneg_ff, szero_ff;
   logic [61:0]        sqc_ff, sqi_ff;
   logic signed [35:0] sx_ff, sy_ff;
   logic signed [31:0] sz_ff;

   logic [30:0]        ac_in, ai_in;
   logic signed [35:0] px_in, py_in, cx_in, cy_in;
   logic signed [31:0] pz_in;

   logic          iv [SqrtSteps+1];
   cgma_iter_type id [SqrtSteps+1];

   logic        rv_ff;
   logic [31:0] rdata_ff;
   logic [31:0] mag_in, res_in;
   logic signed [31:0] az_in;
   cgma_iter_type last;

   assign en         = !rv_ff || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         step_ff <= 5'd1;
      end else if (csr_valid) begin
         case (cgma_reg_type'(csr_index))
            REG_OUTPUT_MODE:   mode_ff <= csr_data[0];
            REG_STEP_DISTANCE: step_ff <= csr_data;
            default:           ;
         endcase
      end
   end

   cgma_diff u_diff (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_tvalid),
      .cross_back  (req_tdata[31:0]),
      .cross_fwd   (req_tdata[63:32]),
      .inline_back (req_tdata[95:64]),
      .inline_fwd  (req_tdata[127:96]),
      .mode        (mode_ff),
      .step_raw    (step_ff),
      .out_valid   (dv),
      .out_data    (dd)
   );

   // squares and CORDIC quadrant fold
   always_comb begin
      ac_in = dd.crl[31] ? 31'(-dd.crl) : dd.crl[30:0];
      ai_in = dd.inl[31] ? 31'(-dd.inl) : dd.inl[30:0];
      cx_in = 36'(dd.inl);
      cy_in = 36'(dd.crl);
      px_in = cx_in;
      py_in = cy_in;
      pz_in = 32'sd0;
      if (dd.inl[31]) begin
         if (!dd.crl[31]) begin
            px_in = cy_in;
            py_in = -cx_in;
            pz_in = Deg90;
         end else begin
            px_in = -cy_in;
            py_in = cx_in;
            pz_in = -Deg90;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff <= 1'b0;
      end else if (en) begin
         sv_ff <= dv;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         smode_ff <= dd.mode;
         sneg_ff  <= dd.neg;
         szero_ff <= (dd.crl == 32'sd0) && (dd.inl == 32'sd0);
         sqc_ff   <= 62'(ac_in) * 62'(ac_in);
         sqi_ff   <= 62'(ai_in) * 62'(ai_in);
         sx_ff    <= px_in;
         sy_ff    <= py_in;
         sz_ff    <= pz_in;
      end
   end

   always_comb begin
      iv[0]      = sv_ff;
      id[0].mode = smode_ff;
      id[0].neg  = sneg_ff;
      id[0].zero = szero_ff;
      id[0].n    = 64'(sqc_ff) + 64'(sqi_ff);
      id[0].rem  = 35'd0;
      id[0].root = 32'd0;
      id[0].x    = sx_ff;
      id[0].y    = sy_ff;
      id[0].z    = sz_ff;
   end

   for (genvar g = 0; g < SqrtSteps; g++) begin : g_iter
      cgma_iter #(
         .INDEX         (g),
         .CORDIC_STAGES (CORDIC_STAGES)
      ) u_iter (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (iv[g]),
         .in_data   (id[g]),
         .out_valid (iv[g+1]),
         .out_data  (id[g+1])
      );
   end

   always_comb begin
      last   = id[SqrtSteps];
      mag_in = (last.root > MagLimit) ? MagLimit : last.root;
      if (last.zero) begin
         az_in = 32'sd0;
      end else if (last.z > Deg180) begin
         az_in = Deg180;
      end else if (last.z < -Deg180) begin
         az_in = -Deg180;
      end else begin
         az_in = last.z;
      end
      if (last.mode == 1'(ModeMag)) begin
         res_in = last.neg ? -mag_in : mag_in;
      end else begin
         res_in = az_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (en) begin
         rv_ff <= iv[SqrtSteps];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rdata_ff <= res_in;
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rdata_ff;

endmodule

/* hw/rtl/cgma_checker.sv */
// Port checker for the gradient magnitude / azimuth block, bound to the top level.
`include "assert_macros.svh"

module cgma_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [127:0] req_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [31:0]  rsp_tdata,
   input logic         csr_valid,
   input logic         csr_ready,
   input logic         csr_index,
   input logic [4:0]   csr_data
);

   `CHECK_ALL(a_reset_empty, clock, reset |=> !rsp_tvalid, "rsp_tvalid after reset")
   `CHECK_RUN(a_stall_backpressure, clock, reset, (rsp_tvalid && !rsp_tready) |-> !req_tready, "req_tready while output stalled")
   `CHECK_RUN(a_csr_ready, clock, reset, csr_ready, "csr_ready low")
   `CHECK_RUN(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "stalled transaction changed")

endmodule

bind curvature_gradient_magnitude_azimuth cgma_checker u_cgma_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready),
   .csr_index  (csr_index),
   .csr_data   (csr_data)
);
